[rtl/core/mmp_pkg.sv]
// Shared types and constants for the multichannel motor PWM block.
package mmp_pkg;

    // Field widths
    localparam int OPCODE_W = 2;
    localparam int MOTOR_W  = 3;
    localparam int SPEED_W  = 8;
    localparam int DUTY_W   = 7;
    localparam int PINS     = 8;
    localparam int COUNT_W  = 4;
    localparam int PHASE_W  = 8;
    localparam int CFG_W    = 4;

    // Default channel count
    localparam int MOTORS_DEF = 8;

    // PWM period and duty limits
    localparam logic [PHASE_W-1:0] PERIOD_LAST     = 8'd99;
    localparam logic [PHASE_W-1:0] COUNTER_RESTART = 8'hFF;
    localparam logic [DUTY_W-1:0]  DUTY_MAX        = 7'd100;

    // Decoupling queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Input opcodes
    localparam logic [OPCODE_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_RUN    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_STOP   = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_TOGGLE = 2'd3;

    // Command class after decode
    typedef enum logic [2:0] {
        KIND_NOP,
        KIND_TICK,
        KIND_RUN,
        KIND_STOP,
        KIND_TOGGLE
    } kind_t;

    // Decoded command word carried through the queue
    typedef struct packed {
        kind_t              kind;
        logic [MOTOR_W-1:0] motor;
        logic [DUTY_W-1:0]  duty;
        logic               fwd;
    } cmd_t;

endpackage

[rtl/core/mmp_front.sv]
// Front decode: classifies a command word and folds speed into duty and direction.
module mmp_front #(
    parameter int MOTORS = mmp_pkg::MOTORS_DEF
) (
    input  logic [mmp_pkg::OPCODE_W-1:0]      opcode,
    input  logic [mmp_pkg::MOTOR_W-1:0]       motor,
    input  logic signed [mmp_pkg::SPEED_W-1:0] speed,
    output mmp_pkg::cmd_t                     cmd
);
    import mmp_pkg::*;

    logic [SPEED_W-1:0] mag;
    logic               motor_ok;

    // Magnitude of speed; -128 comes out as 128 unsigned
    assign mag = speed[SPEED_W-1] ? SPEED_W'(-speed) : SPEED_W'(speed);

    assign motor_ok = (int'(motor) < MOTORS);

    // Classify and saturate duty
    always_comb
    begin
        cmd.motor = motor;
        cmd.duty  = (mag > SPEED_W'(DUTY_MAX)) ? DUTY_MAX : mag[DUTY_W-1:0];
        cmd.fwd   = !speed[SPEED_W-1] && (speed != '0);
        case (opcode)
            OP_TICK:   cmd.kind = KIND_TICK;
            OP_RUN:    cmd.kind = motor_ok ? KIND_RUN : KIND_NOP;
            OP_STOP:   cmd.kind = motor_ok ? KIND_STOP : KIND_NOP;
            OP_TOGGLE: cmd.kind = motor_ok ? KIND_TOGGLE : KIND_NOP;
            default:   cmd.kind = KIND_NOP;
        endcase
    end

endmodule

[rtl/core/mmp_queue.sv]
// Two-entry queue of decoded command words between front and back.
module mmp_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  mmp_pkg::cmd_t push_word,
    output logic          pop_valid,
    input  logic          pop_ready,
    output mmp_pkg::cmd_t pop_word
);
    import mmp_pkg::*;

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push, pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_word   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Pointer and fill update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_word;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue fill above depth");
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (rd_ptr_reg == wr_ptr_reg))
        else $error("empty queue with pointers apart");
    a_full_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == QCNT_W'(QUEUE_DEPTH)) |-> (rd_ptr_reg == wr_ptr_reg))
        else $error("full queue with pointers apart");

endmodule

[rtl/core/mmp_back.sv]
// Back end: PWM phase counter, per-channel compares, run/stop state and result word.
module mmp_back #(
    parameter int MOTORS = mmp_pkg::MOTORS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    input  logic [mmp_pkg::CFG_W-1:0]    cfg_data,
    input  logic                         q_valid,
    output logic                         q_ready,
    input  mmp_pkg::cmd_t                q_word,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [mmp_pkg::PINS-1:0]     enable_pins,
    output logic [mmp_pkg::PINS-1:0]     forward_pins,
    output logic [mmp_pkg::PINS-1:0]     reverse_pins,
    output logic [mmp_pkg::COUNT_W-1:0]  running_count
);
    import mmp_pkg::*;

    // Channels reachable through the motor field and the pin vectors
    localparam int CH = (MOTORS > PINS) ? PINS : MOTORS;

    logic [CFG_W-1:0]   cfg_reg;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [DUTY_W-1:0]  req_reg [CH];
    logic [DUTY_W-1:0]  req_next [CH];
    logic [DUTY_W-1:0]  sh_reg [CH];
    logic [DUTY_W-1:0]  sh_next [CH];
    logic [PINS-1:0]    nl_reg, nl_next;
    logic [PINS-1:0]    en_reg, en_next;
    logic [PINS-1:0]    flags_reg, flags_next;
    logic [COUNT_W-1:0] total_reg, total_next;
    logic [PINS-1:0]    fwd_reg, fwd_next;
    logic [PINS-1:0]    rev_reg, rev_next;
    logic               out_valid_reg, out_valid_next;
    logic               pop;
    logic               do_tick, do_run, do_stop;
    logic [PHASE_W-1:0] ph1;
    logic               is_running;

    assign q_ready    = !out_valid_reg || out_ready;
    assign pop        = q_valid && q_ready;
    assign is_running = flags_reg[q_word.motor];
    assign ph1        = phase_reg + 1'b1;

    // Command dispatch; toggle resolves against the running flag
    always_comb
    begin
        do_tick = 1'b0;
        do_run  = 1'b0;
        do_stop = 1'b0;
        if (pop)
        begin
            case (q_word.kind)
                KIND_TICK:   do_tick = 1'b1;
                KIND_RUN:    do_run = 1'b1;
                KIND_STOP:   do_stop = 1'b1;
                KIND_TOGGLE:
                begin
                    do_stop = is_running;
                    do_run  = !is_running;
                end
                default:     ;
            endcase
        end
    end

    // State update for one command
    always_comb
    begin
        phase_next = phase_reg;
        req_next   = req_reg;
        sh_next    = sh_reg;
        nl_next    = nl_reg;
        en_next    = en_reg;
        flags_next = flags_reg;
        total_next = total_reg;
        fwd_next   = fwd_reg;
        rev_next   = rev_reg;

        // PWM tick, frozen while nothing runs
        if (do_tick && (total_reg != '0))
        begin
            en_next = nl_reg;
            if (ph1 == '0)
            begin
                for (int i = 0; i < CH; i++)
                begin
                    if (CFG_W'(i) < cfg_reg)
                        sh_next[i] = req_reg[i];
                end
                for (int i = 0; i < PINS; i++)
                    nl_next[i] = (i < CH) && (CFG_W'(i) < cfg_reg);
            end
            for (int i = 0; i < CH; i++)
            begin
                if ((CFG_W'(i) < cfg_reg) && ({1'b0, sh_next[i]} == ph1))
                    nl_next[i] = 1'b0;
            end
            phase_next = (ph1 == PERIOD_LAST) ? COUNTER_RESTART : ph1;
        end

        // Run: duty, direction, running flag
        if (do_run)
        begin
            for (int i = 0; i < CH; i++)
            begin
                if (MOTOR_W'(i) == q_word.motor)
                    req_next[i] = q_word.duty;
            end
            fwd_next[q_word.motor] = q_word.fwd;
            rev_next[q_word.motor] = !q_word.fwd;
            if (!is_running)
            begin
                flags_next[q_word.motor] = 1'b1;
                total_next = total_reg + 1'b1;
            end
        end

        // Stop: clear duty, drop enable at once if running
        if (do_stop)
        begin
            for (int i = 0; i < CH; i++)
            begin
                if (MOTOR_W'(i) == q_word.motor)
                    req_next[i] = '0;
            end
            if (is_running)
            begin
                flags_next[q_word.motor] = 1'b0;
                total_next = total_reg - 1'b1;
                en_next[q_word.motor] = 1'b0;
            end
        end
    end

    // Result word handshake
    always_comb
    begin
        if (pop)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= '0;
            phase_reg     <= COUNTER_RESTART;
            nl_reg        <= '0;
            en_reg        <= '0;
            flags_reg     <= '0;
            total_reg     <= '0;
            fwd_reg       <= '0;
            rev_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CH; i++)
            begin
                req_reg[i] <= '0;
                sh_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_valid)
                cfg_reg <= cfg_data;
            phase_reg     <= phase_next;
            nl_reg        <= nl_next;
            en_reg        <= en_next;
            flags_reg     <= flags_next;
            total_reg     <= total_next;
            fwd_reg       <= fwd_next;
            rev_reg       <= rev_next;
            out_valid_reg <= out_valid_next;
            req_reg       <= req_next;
            sh_reg        <= sh_next;
        end
    end

    // State registers hold still while the result word waits
    assign out_valid     = out_valid_reg;
    assign enable_pins   = en_reg;
    assign forward_pins  = fwd_reg;
    assign reverse_pins  = rev_reg;
    assign running_count = total_reg;

    a_total_matches: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg == COUNT_W'($countones(flags_reg)))
        else $error("run total differs from running flags");
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == COUNTER_RESTART) || (phase_reg < PERIOD_LAST))
        else $error("phase counter out of period");
    a_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
        !pop |=> $stable(phase_reg) && $stable(flags_reg))
        else $error("state moved without a command");
    a_dir_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (fwd_reg & rev_reg) == '0)
        else $error("both bridge inputs high");

endmodule

[rtl/core/multichannel_motor_pwm.sv]
// An accepted word waits in the two-entry queue; the back end pops it and registers the result.
// One word per cycle while out_ready keeps up; queue and result register decouple the sides.
// The per-channel duty compares run in parallel.
// Reset (async, active low): all duties, pins and counts clear, phase counter 255, queue empty.
// No clearing pass after reset; the block takes words as soon as reset is released.
module multichannel_motor_pwm #(
    parameter int MOTORS = mmp_pkg::MOTORS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [mmp_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [mmp_pkg::OPCODE_W-1:0]  opcode,
    input  logic [mmp_pkg::MOTOR_W-1:0]   motor,
    input  logic signed [mmp_pkg::SPEED_W-1:0] speed,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mmp_pkg::PINS-1:0]      enable_pins,
    output logic [mmp_pkg::PINS-1:0]      forward_pins,
    output logic [mmp_pkg::PINS-1:0]      reverse_pins,
    output logic [mmp_pkg::COUNT_W-1:0]   running_count
);
    import mmp_pkg::*;

    cmd_t dec_word;
    cmd_t q_word;
    logic q_valid;
    logic q_ready;

    // Register write is always taken
    assign cfg_ready = 1'b1;

    // Decode
    mmp_front #(
        .MOTORS (MOTORS)
    ) u_front (
        .opcode (opcode),
        .motor  (motor),
        .speed  (speed),
        .cmd    (dec_word)
    );

    // Decoupling queue
    mmp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_word  (dec_word),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_word   (q_word)
    );

    // Execute and present result
    mmp_back #(
        .MOTORS (MOTORS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_word        (q_word),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .enable_pins   (enable_pins),
        .forward_pins  (forward_pins),
        .reverse_pins  (reverse_pins),
        .running_count (running_count)
    );

endmodule

[sim/mmp_pin_checker.sv]
// Pin-level predictor and result checker for the multichannel motor PWM block.
module mmp_pin_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [mmp_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic [mmp_pkg::OPCODE_W-1:0]        opcode,
    input  logic [mmp_pkg::MOTOR_W-1:0]         motor,
    input  logic signed [mmp_pkg::SPEED_W-1:0]  speed,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [mmp_pkg::PINS-1:0]            enable_pins,
    input  logic [mmp_pkg::PINS-1:0]            forward_pins,
    input  logic [mmp_pkg::PINS-1:0]            reverse_pins,
    input  logic [mmp_pkg::COUNT_W-1:0]         running_count,
    output int                                  pending,
    output int                                  fail_count
);

    timeunit 1ns;
    timeprecision 1ps;

    import mmp_pkg::*;

    typedef struct packed {
        logic [PINS-1:0]    enable_lv;
        logic [PINS-1:0]    fwd_lv;
        logic [PINS-1:0]    rev_lv;
        logic [COUNT_W-1:0] run_cnt;
    } pin_state_t;

    // Predicted block state
    logic [CFG_W-1:0]   motors_cfg;
    logic [PHASE_W-1:0] phase_cnt;
    logic [DUTY_W-1:0]  duty_req     [MOTORS_DEF];
    logic [DUTY_W-1:0]  duty_latched [MOTORS_DEF];
    logic [PINS-1:0]    pending_levels;
    logic [PINS-1:0]    enable_reg;
    logic [PINS-1:0]    run_flags;
    logic [COUNT_W-1:0] run_total;
    logic [PINS-1:0]    fwd_levels;
    logic [PINS-1:0]    rev_levels;

    pin_state_t expected_pins [$];
    pin_state_t want_pins;
    pin_state_t got_pins;

    function automatic void clear_model();
        motors_cfg     = '0;
        phase_cnt      = COUNTER_RESTART;
        pending_levels = '0;
        enable_reg     = '0;
        run_flags      = '0;
        run_total      = '0;
        fwd_levels     = '0;
        rev_levels     = '0;
        for (int i = 0; i < MOTORS_DEF; i++)
        begin
            duty_req[i]     = '0;
            duty_latched[i] = '0;
        end
    endfunction

    // One PWM step; frozen while no motor runs
    function automatic void pwm_tick();
        int n;
        n = (motors_cfg > MOTORS_DEF) ? MOTORS_DEF : int'(motors_cfg);
        if (run_total == '0)
            return;
        enable_reg = pending_levels;
        phase_cnt  = phase_cnt + 8'd1;
        // period start: latch duties, raise enables of motors in use
        if (phase_cnt == '0)
        begin
            pending_levels = '0;
            for (int i = 0; i < n; i++)
            begin
                duty_latched[i]   = duty_req[i];
                pending_levels[i] = 1'b1;
            end
        end
        for (int i = 0; i < n; i++)
        begin
            if ({1'b0, duty_latched[i]} == phase_cnt)
                pending_levels[i] = 1'b0;
        end
        if (phase_cnt == PERIOD_LAST)
            phase_cnt = COUNTER_RESTART;
    endfunction

    // Magnitude saturates at full duty; zero speed counts as reverse
    function automatic void motor_run(logic [MOTOR_W-1:0] m, logic signed [SPEED_W-1:0] sp);
        int s;
        int mag;
        s   = sp;
        mag = (s < 0) ? -s : s;
        if (mag > int'(DUTY_MAX))
            mag = DUTY_MAX;
        duty_req[m] = DUTY_W'(mag);
        fwd_levels[m] = (s > 0);
        rev_levels[m] = !(s > 0);
        if (!run_flags[m])
        begin
            run_flags[m] = 1'b1;
            run_total    = run_total + 1'b1;
        end
    endfunction

    // Running motor loses its enable at once; pending level is left alone
    function automatic void motor_stop(logic [MOTOR_W-1:0] m);
        duty_req[m] = '0;
        if (run_flags[m])
        begin
            run_flags[m]  = 1'b0;
            run_total     = run_total - 1'b1;
            enable_reg[m] = 1'b0;
        end
    endfunction

    function automatic void check_field(string name, logic [PINS-1:0] want, logic [PINS-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Watch the three channels; results are checked before the new word is applied
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_model();
            expected_pins.delete();
            fail_count = 0;
            pending   <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got_pins = '{enable_pins, forward_pins, reverse_pins, running_count};
                if (expected_pins.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, actual %h",
                             $time, got_pins);
                    fail_count++;
                end
                else
                begin
                    want_pins = expected_pins.pop_front();
                    check_field("enable_pins", want_pins.enable_lv, got_pins.enable_lv);
                    check_field("forward_pins", want_pins.fwd_lv, got_pins.fwd_lv);
                    check_field("reverse_pins", want_pins.rev_lv, got_pins.rev_lv);
                    check_field("running_count", PINS'(want_pins.run_cnt),
                                PINS'(got_pins.run_cnt));
                end
            end

            if (cfg_valid && cfg_ready)
                motors_cfg = cfg_data;

            if (in_valid && in_ready)
            begin
                case (opcode)
                    OP_TICK:   pwm_tick();
                    OP_RUN:    motor_run(motor, speed);
                    OP_STOP:   motor_stop(motor);
                    OP_TOGGLE:
                    begin
                        if (run_flags[motor])
                            motor_stop(motor);
                        else
                            motor_run(motor, speed);
                    end
                    default: ;
                endcase
                expected_pins.push_back('{enable_reg, fwd_levels, rev_levels, run_total});
            end

            pending <= expected_pins.size();
        end
    end

endmodule

[sim/tb_multichannel_motor_pwm.sv]
// Stimulus and verdict for the multichannel motor PWM block.
module tb_multichannel_motor_pwm;

    timeunit 1ns;
    timeprecision 1ps;

    import mmp_pkg::*;

    localparam int STALL_LIMIT = 3000;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_W-1:0]          cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    logic [OPCODE_W-1:0]       opcode;
    logic [MOTOR_W-1:0]        motor;
    logic signed [SPEED_W-1:0] speed;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [PINS-1:0]           enable_pins;
    logic [PINS-1:0]           forward_pins;
    logic [PINS-1:0]           reverse_pins;
    logic [COUNT_W-1:0]        running_count;

    int pending;
    int fail_count;
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int stall_cycles   = 0;

    multichannel_motor_pwm dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .motor         (motor),
        .speed         (speed),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .enable_pins   (enable_pins),
        .forward_pins  (forward_pins),
        .reverse_pins  (reverse_pins),
        .running_count (running_count)
    );

    mmp_pin_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .motor         (motor),
        .speed         (speed),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .enable_pins   (enable_pins),
        .forward_pins  (forward_pins),
        .reverse_pins  (reverse_pins),
        .running_count (running_count),
        .pending       (pending),
        .fail_count    (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side back-pressure
    always @(posedge clk)
        out_ready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);

    // Cycles with no word moving on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Offer one command word, with a random gap before it
    task automatic send_word(logic [OPCODE_W-1:0] op, logic [MOTOR_W-1:0] m,
                             logic [SPEED_W-1:0] sp);
        if ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < send_gap_pct);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        motor    <= m;
        speed    <= sp;
        do @(posedge clk); while (!in_ready);
    endtask

    // Hold off until every result word is back, then let the pipe settle
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_motor_count(logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Mostly ticks so several PWM periods pass; speeds either raw bits or in range
    task automatic send_random_command();
        int                  pick;
        logic [OPCODE_W-1:0] op;
        logic [SPEED_W-1:0]  sp;
        pick = $urandom_range(0, 99);
        if (pick < 74)
            op = OP_TICK;
        else if (pick < 86)
            op = OP_RUN;
        else if (pick < 92)
            op = OP_STOP;
        else
            op = OP_TOGGLE;
        if ($urandom_range(0, 1) == 1)
            sp = SPEED_W'($urandom_range(0, 255));
        else
            sp = SPEED_W'($urandom_range(0, 200) - 100);
        send_word(op, MOTOR_W'($urandom_range(0, 7)), sp);
    endtask

    task automatic run_segment(logic [CFG_W-1:0] motors, int gap_pct, int stall_pct,
                               int count);
        drain_results();
        write_motor_count(motors);
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
        begin
            // occasional full pause of the sender
            if ($urandom_range(0, 99) == 0)
                drain_results();
            send_random_command();
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        opcode    <= OP_TICK;
        motor     <= '0;
        speed     <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: four motors in use, upper channels only get direction pins
        write_motor_count(CFG_W'(4));
        send_word(OP_TICK, 3'd0, 8'sd0);        // idle tick, nothing runs
        send_word(OP_RUN, 3'd0, 8'sd127);       // saturates to full duty
        send_word(OP_RUN, 3'd1, -8'sd128);      // saturates, reverse
        send_word(OP_RUN, 3'd2, 8'sd0);         // zero speed is reverse, duty 0
        send_word(OP_RUN, 3'd3, 8'sd1);
        send_word(OP_RUN, 3'd7, -8'sd100);      // channel not in use
        send_word(OP_RUN, 3'd0, 8'sd50);        // already running: count holds
        send_word(OP_TICK, 3'd5, 8'sd0);
        send_word(OP_TICK, 3'd0, 8'sd0);
        send_word(OP_TICK, 3'd0, 8'sd0);
        send_word(OP_STOP, 3'd1, 8'sd0);        // enable drops at once
        send_word(OP_STOP, 3'd4, 8'sd0);        // not running
        send_word(OP_TOGGLE, 3'd5, 8'sd64);     // toggle on
        send_word(OP_TOGGLE, 3'd5, 8'sd64);     // toggle off
        send_word(OP_TICK, 3'd0, 8'sd0);        // stopped pin may come back
        send_word(OP_TICK, 3'd0, 8'sd0);
        send_word(OP_TOGGLE, 3'd4, -8'sd1);
        send_word(OP_RUN, 3'd6, 8'sd100);
        send_word(OP_STOP, 3'd6, 8'sd0);
        send_word(OP_TICK, 3'd7, -8'sd1);

        run_segment(CFG_W'(15), 21, 78, 120);
        run_segment(CFG_W'($urandom_range(1, 7)), 78, 21, 120);
        run_segment(CFG_W'(0), 0, 0, 60);
        run_segment(CFG_W'(8), 0, 0, 180);

        drain_results();
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
